// ===== hdl/kal3_pkg.sv =====
// ----------------------------------------------------------------------------
// kal3_pkg
// Shared widths, register indexes and helper functions for the three-axis
// scalar Kalman filter.
// ----------------------------------------------------------------------------
package kal3_pkg;

  // Value format: signed, FRAC_BITS fraction bits.
  localparam int VAL_W     = 40;
  localparam int FRAC_BITS = 32;
  localparam int CFG_W     = 32;
  localparam int AXES_DEF  = 3;

  // Product result width after the fraction shift (magnitude stays below 2^47).
  localparam int PROD_W    = 48;

  // Serial unit step counts.
  localparam int DIV_STEPS = VAL_W + FRAC_BITS;
  localparam int MUL_STEPS = VAL_W;

  // Wide sum width used before saturation.
  localparam int SUM_W     = PROD_W + 2;

  // Register reset values.
  localparam logic [CFG_W-1:0] PROC_NOISE_RST = CFG_W'(4295);
  localparam logic [CFG_W-1:0] MEAS_NOISE_RST = CFG_W'(85899);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_PROC_NOISE = 1'b0,
    CFG_MEAS_NOISE = 1'b1
  } cfg_idx_t;

  // Clamp a wide signed value into the 40-bit signed range.
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'({1'b0, {(VAL_W-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (x > hi) begin
      sat_val = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (x < lo) begin
      sat_val = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_val = x[VAL_W-1:0];
    end
  endfunction

endpackage

// ===== hdl/kal3_div.sv =====
// ----------------------------------------------------------------------------
// kal3_div
// Bit-serial restoring divider: (num << FRAC_BITS) / den on magnitudes, one
// quotient bit per cycle, quotient magnitude saturated at 2^39-1.
// ----------------------------------------------------------------------------
module kal3_div
  import kal3_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] num_mag,
  input  logic [VAL_W:0]   den_mag,
  output logic             done,
  output logic [VAL_W-1:0] q_mag
);

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [VAL_W-1:0] num_r, num_nxt;
  logic [VAL_W:0]   den_r, den_nxt;
  logic [VAL_W:0]   rem_r, rem_nxt;
  logic [VAL_W-2:0] q_r, q_nxt;
  logic             ovf_r, ovf_nxt;
  logic [VAL_W+1:0] trial;
  logic [VAL_W+1:0] diff;
  logic             ge;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial    = {rem_r, num_r[VAL_W-1]};
    diff     = trial - {1'b0, den_r};
    ge       = (trial >= {1'b0, den_r});
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    ovf_nxt  = ovf_r;
    if (start) begin
      cnt_nxt = '0;
      run_nxt = 1'b1;
      num_nxt = num_mag;
      den_nxt = den_mag;
      rem_nxt = '0;
      q_nxt   = '0;
      ovf_nxt = 1'b0;
    end else if (run_r) begin
      num_nxt = {num_r[VAL_W-2:0], 1'b0};
      rem_nxt = ge ? diff[VAL_W:0] : trial[VAL_W:0];
      q_nxt   = {q_r[VAL_W-3:0], ge};
      // Once the quotient passes the limit it can only grow.
      ovf_nxt = ovf_r | q_r[VAL_W-2];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    ovf_r <= ovf_nxt;
  end

  assign done  = done_r;
  assign q_mag = ovf_r ? {1'b0, {(VAL_W-1){1'b1}}} : {1'b0, q_r};

endmodule

// ===== hdl/kal3_mul.sv =====
// ----------------------------------------------------------------------------
// kal3_mul
// Bit-serial shift-add multiplier: signed (a*b) >> FRAC_BITS with floor
// rounding, one multiplier bit per cycle, then a final step to apply the sign.
// ----------------------------------------------------------------------------
module kal3_mul
  import kal3_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [VAL_W:0]           mcand_mag,
  input  logic [VAL_W-1:0]         mplier_mag,
  input  logic                     neg,
  output logic                     done,
  output logic signed [PROD_W-1:0] prod
);

  localparam int CNT_W = $clog2(MUL_STEPS + 1);

  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     run_r, run_nxt;
  logic                     done_r, done_nxt;
  logic [VAL_W:0]           mcand_r, mcand_nxt;
  logic [VAL_W-1:0]         mpl_r, mpl_nxt;
  logic                     neg_r, neg_nxt;
  logic [VAL_W:0]           acc_r, acc_nxt;
  logic [VAL_W-1:0]         low_r, low_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [VAL_W+1:0]         sum;
  logic [PROD_W-1:0]        res;
  logic                     lost;

  // Add the multiplicand for the current bit, then shift the partial product.
  always_comb begin
    sum       = {1'b0, acc_r} + (mpl_r[0] ? {1'b0, mcand_r} : '0);
    res       = {acc_r[PROD_W-1-(VAL_W-FRAC_BITS):0], low_r[VAL_W-1:FRAC_BITS]};
    lost      = |low_r[FRAC_BITS-1:0];
    cnt_nxt   = cnt_r;
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    mcand_nxt = mcand_r;
    mpl_nxt   = mpl_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    low_nxt   = low_r;
    prod_nxt  = prod_r;
    if (start) begin
      cnt_nxt   = '0;
      run_nxt   = 1'b1;
      mcand_nxt = mcand_mag;
      mpl_nxt   = mplier_mag;
      neg_nxt   = neg;
      acc_nxt   = '0;
      low_nxt   = '0;
    end else if (run_r) begin
      if (cnt_r == CNT_W'(MUL_STEPS)) begin
        // Floor rounding: a negative result with dropped bits moves down by one.
        prod_nxt = neg_r ? -$signed(res + PROD_W'(lost)) : $signed(res);
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        acc_nxt = sum[VAL_W+1:1];
        low_nxt = {sum[0], low_r[VAL_W-1:1]};
        mpl_nxt = {1'b0, mpl_r[VAL_W-1:1]};
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mcand_r <= mcand_nxt;
    mpl_r   <= mpl_nxt;
    neg_r   <= neg_nxt;
    acc_r   <= acc_nxt;
    low_r   <= low_nxt;
    prod_r  <= prod_nxt;
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

// ===== hdl/three_axis_scalar_kalman.sv =====
// ----------------------------------------------------------------------------
// three_axis_scalar_kalman
// Independent constant-model scalar Kalman filters, one per axis, with a
// shared bit-serial divider and two bit-serial multipliers.
// ----------------------------------------------------------------------------
// One sample beat produces one result beat. The axes are processed one after
// another; each axis goes through a setup state, the serial divider
// (one quotient bit per cycle over 72 bits), a second setup state, and the
// two serial multipliers running side by side; when they finish, the new
// estimate and variance are written. The first sample after reset seeds
// each estimate and variance with its measurement. A zero gain denominator
// gives zero gain and sets the fault flag in out_tuser.
module three_axis_scalar_kalman
  import kal3_pkg::*;
#(
  parameter int AXES = AXES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Sample channel. tdata: meas_x, meas_y, meas_z, ... (40 bits each, from bit 0 up)
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [AXES*VAL_W-1:0] in_tdata,
  // Result channel. tdata: est_x, est_y, est_z, ... (40 bits each, from bit 0 up)
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [AXES*VAL_W-1:0] out_tdata,
  // tuser: divide_fault
  output logic                  out_tuser,
  // Configuration write port
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int AX_W = (AXES > 1) ? $clog2(AXES) : 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DGO   = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_MGO   = 6'b001000,
    ST_MUL   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [AX_W-1:0]          ax_r, ax_nxt;
  logic                     primed_r, primed_nxt;
  logic                     fault_r, fault_nxt;
  logic [CFG_W-1:0]         pn_r, mn_r;
  logic signed [VAL_W-1:0]  meas_r [AXES];
  logic signed [VAL_W-1:0]  est_r  [AXES];
  logic signed [VAL_W-1:0]  var_r  [AXES];
  logic [VAL_W-1:0]         gmag_r, gmag_nxt;
  logic                     gneg_r, gneg_nxt;
  logic                     dzero_r, dzero_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [AXES*VAL_W-1:0]    out_data_r;
  logic                     out_fault_r;

  logic signed [VAL_W-1:0]  v_cur, e_cur, m_cur;
  logic signed [VAL_W:0]    den;
  logic signed [VAL_W:0]    diff;
  logic [VAL_W:0]           den_mag, diff_mag;
  logic [VAL_W-1:0]         v_mag;
  logic                     accept;
  logic                     div_start, div_done;
  logic [VAL_W-1:0]         q_mag;
  logic                     mul_start, mul1_done, mul2_done;
  logic signed [PROD_W-1:0] prod1, prod2;
  logic signed [VAL_W-1:0]  est_new, var_new;
  logic                     upd;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  // Operands of the axis under work.
  always_comb begin
    v_cur    = var_r[ax_r];
    e_cur    = est_r[ax_r];
    m_cur    = meas_r[ax_r];
    den      = (VAL_W+1)'(v_cur) + $signed({{(VAL_W+1-CFG_W){1'b0}}, mn_r});
    den_mag  = den[VAL_W] ? (VAL_W+1)'(-den) : den;
    v_mag    = v_cur[VAL_W-1] ? VAL_W'(-v_cur) : v_cur;
    diff     = (VAL_W+1)'(m_cur) - (VAL_W+1)'(e_cur);
    diff_mag = diff[VAL_W] ? (VAL_W+1)'(-diff) : diff;
  end

  kal3_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_mag (v_mag),
    .den_mag (den_mag),
    .done    (div_done),
    .q_mag   (q_mag)
  );

  // gain * (meas - estimate)
  kal3_mul u_mul_est (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (mul_start),
    .mcand_mag  (diff_mag),
    .mplier_mag (gmag_r),
    .neg        (gneg_r ^ diff[VAL_W]),
    .done       (mul1_done),
    .prod       (prod1)
  );

  // gain * variance
  kal3_mul u_mul_var (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (mul_start),
    .mcand_mag  ({1'b0, v_mag}),
    .mplier_mag (gmag_r),
    .neg        (gneg_r ^ v_cur[VAL_W-1]),
    .done       (mul2_done),
    .prod       (prod2)
  );

  // New state values, saturated to the 40-bit range.
  always_comb begin
    est_new = sat_val(SUM_W'(e_cur) + SUM_W'(prod1));
    var_new = sat_val(SUM_W'(v_cur) - SUM_W'(prod2)
                      + $signed({{(SUM_W-CFG_W){1'b0}}, pn_r}));
  end

  // Sequencer over the axes.
  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    primed_nxt    = primed_r;
    fault_nxt     = fault_r;
    gmag_nxt      = gmag_r;
    gneg_nxt      = gneg_r;
    dzero_nxt     = dzero_r;
    out_valid_nxt = out_valid_r;
    div_start     = 1'b0;
    mul_start     = 1'b0;
    upd           = 1'b0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          primed_nxt = 1'b1;
          fault_nxt  = 1'b0;
          ax_nxt     = '0;
          state_nxt  = ST_DGO;
        end
      end
      ST_DGO: begin
        div_start = 1'b1;
        dzero_nxt = (den == '0);
        gneg_nxt  = v_cur[VAL_W-1] ^ den[VAL_W];
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          gmag_nxt  = dzero_r ? '0 : q_mag;
          fault_nxt = fault_r | dzero_r;
          state_nxt = ST_MGO;
        end
      end
      ST_MGO: begin
        mul_start = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mul1_done) begin
          upd = 1'b1;
          if (ax_r == AX_W'(AXES - 1)) begin
            state_nxt = ST_EMIT;
          end else begin
            ax_nxt    = ax_r + AX_W'(1);
            state_nxt = ST_DGO;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ax_r        <= '0;
      primed_r    <= 1'b0;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
      pn_r        <= PROC_NOISE_RST;
      mn_r        <= MEAS_NOISE_RST;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      primed_r    <= primed_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PROC_NOISE: pn_r <= cfg_wdata;
          CFG_MEAS_NOISE: mn_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    gmag_r  <= gmag_nxt;
    gneg_r  <= gneg_nxt;
    dzero_r <= dzero_nxt;
  end

  // Per-axis state: reset to zero, seeded by the first sample.
  always_ff @(posedge clk) begin
    for (int i = 0; i < AXES; i++) begin
      if (!rst_n) begin
        est_r[i] <= '0;
        var_r[i] <= '0;
      end else if (accept && !primed_r) begin
        est_r[i] <= in_tdata[i*VAL_W +: VAL_W];
        var_r[i] <= in_tdata[i*VAL_W +: VAL_W];
      end else if (upd && (ax_r == AX_W'(i))) begin
        est_r[i] <= est_new;
        var_r[i] <= var_new;
      end
    end
  end

  // Captured measurements and the result register.
  always_ff @(posedge clk) begin
    for (int i = 0; i < AXES; i++) begin
      if (accept) begin
        meas_r[i] <= in_tdata[i*VAL_W +: VAL_W];
      end
    end
    if (state_r == ST_EMIT && (!out_valid_r || out_tready)) begin
      for (int i = 0; i < AXES; i++) begin
        out_data_r[i*VAL_W +: VAL_W] <= est_r[i];
      end
      out_fault_r <= fault_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_fault_r;

  // A sample beat closes the input until its result is queued.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("input accepted again while a sample is in work");

  // The axis counter never leaves the axis range.
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    ax_r <= AX_W'(AXES - 1))
    else $error("axis counter out of range");

  // Once seeded, the filter stays seeded until reset.
  a_primed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    primed_r |=> primed_r)
    else $error("seed flag dropped");

  // Both multipliers finish together.
  a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    mul1_done == mul2_done)
    else $error("multipliers out of step");

endmodule
